@@ src/slcalc_pkg.sv @@
// ----------------------------------------------------------------------------
// slcalc_pkg
// Shared constants for the serial line four-operation calculator: character
// codes, line phases, parser steps, operation modes, sequencer states and
// status codes.
// ----------------------------------------------------------------------------
package slcalc_pkg;

   localparam int DATA_WIDTH_DEFAULT = 16;

   localparam int RESULT_WIDTH = 16;
   localparam int BYTE_WIDTH   = 8;
   localparam int STATUS_WIDTH = 2;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_VT    = 8'd11;
   localparam logic [7:0] CHAR_FF    = 8'd12;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_SLASH = 8'd47;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_X     = 8'd120;

   // line phases
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_OPER   = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;
   localparam logic [1:0] PH_CALC   = 2'd3;

   // number parser steps
   localparam logic [1:0] PS_BLANK  = 2'd0;
   localparam logic [1:0] PS_DIGITS = 2'd1;
   localparam logic [1:0] PS_STOP   = 2'd2;

   // arithmetic modes
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_MUL = 2'd1;
   localparam logic [1:0] MODE_DIV = 2'd2;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // result status
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
   localparam logic [1:0] STAT_BAD_OP   = 2'd2;

endpackage

@@ src/serial_line_four_op_calculator.sv @@
// ----------------------------------------------------------------------------
// serial_line_four_op_calculator
// Line-oriented calculator: parses operand and operator lines from received
// bytes and computes +, -, x or / bit-serially on every fourth line end.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                   | handshake
//  req     | in        | req_rx_byte                             | req_valid / req_stall
//  rsp     | out       | rsp_result_value, rsp_status            | rsp_valid / rsp_stall
//
//  A byte that does not close the compute line leaves req_stall low.
//  The compute line end starts the arithmetic sequencer: the serial adder,
//  shift-add multiplier or restoring divider retires one bit per cycle;
//  divide by zero and unknown operators skip the serial pass.
//  req_stall is high while a transaction is in the arithmetic sequencer.
//  A finished result waits in the sequencer while rsp_stall holds the output
//  register. Synchronous reset clears line, parser and operand state.
// ----------------------------------------------------------------------------
module serial_line_four_op_calculator
   import slcalc_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [BYTE_WIDTH-1:0]          req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [RESULT_WIDTH-1:0] rsp_result_value,
   output logic [STATUS_WIDTH-1:0]        rsp_status
);

   localparam int W     = DATA_WIDTH;
   localparam int CNT_W = $clog2(DATA_WIDTH);

   logic [1:0]              state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   logic [W-1:0]            first_ff, first_in;
   logic [W-1:0]            second_ff, second_in;
   logic [BYTE_WIDTH-1:0]   op_ff, op_in;
   logic [W-1:0]            accum_ff, accum_in;
   logic [1:0]              pstep_ff, pstep_in;
   logic                    neg_sign_ff, neg_sign_in;
   logic                    line_start_ff, line_start_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [1:0]              mode_ff, mode_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [W-1:0]            x_ff, x_in;
   logic [W-1:0]            y_ff, y_in;
   logic [W:0]              acc_ff, acc_in;
   logic                    carry_ff, carry_in;
   logic                    qneg_ff, qneg_in;
   logic [STATUS_WIDTH-1:0] stat_ff, stat_in;
   logic [RESULT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    is_eol;
   logic                    is_digit;
   logic                    is_blank;
   logic [3:0]              digit;
   logic [W-1:0]            parsed;
   logic [W-1:0]            accum_x10;
   logic [W-1:0]            mag_a;
   logic [W-1:0]            mag_b;
   logic                    sum_bit;
   logic                    sum_carry;
   logic [W:0]              rem_shift;
   logic [W:0]              rem_diff;
   logic [W-1:0]            final_val;
   logic [W+RESULT_WIDTH-1:0] final_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign is_eol   = (req_rx_byte == CHAR_LF) || (req_rx_byte == CHAR_CR);
   assign is_digit = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
   assign is_blank = (req_rx_byte == CHAR_TAB) || (req_rx_byte == CHAR_VT) ||
                     (req_rx_byte == CHAR_FF) || (req_rx_byte == CHAR_SPACE);
   assign digit    = 4'(req_rx_byte - CHAR_ZERO);

   assign parsed    = neg_sign_ff ? (W'(0) - accum_ff) : accum_ff;
   assign accum_x10 = {accum_ff[W-4:0], 3'b000} + {accum_ff[W-2:0], 1'b0} + W'(digit);

   assign mag_a = first_ff[W-1]  ? (W'(0) - first_ff)  : first_ff;
   assign mag_b = second_ff[W-1] ? (W'(0) - second_ff) : second_ff;

   assign sum_bit   = x_ff[0] ^ y_ff[0] ^ carry_ff;
   assign sum_carry = (x_ff[0] & y_ff[0]) | (x_ff[0] & carry_ff) | (y_ff[0] & carry_ff);

   assign rem_shift = {acc_ff[W-1:0], x_ff[W-1]};
   assign rem_diff  = rem_shift - {1'b0, y_ff};

   always_comb begin
      if (mode_ff == MODE_DIV) begin
         final_val = qneg_ff ? (W'(0) - x_ff) : x_ff;
      end else begin
         final_val = acc_ff[W-1:0];
      end
   end

   assign final_wide = {{RESULT_WIDTH{1'b0}}, final_val};

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      op_in         = op_ff;
      accum_in      = accum_ff;
      pstep_in      = pstep_ff;
      neg_sign_in   = neg_sign_ff;
      line_start_in = line_start_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      carry_in      = carry_ff;
      qneg_in       = qneg_ff;
      stat_in       = stat_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_eol) begin
                  unique case (phase_ff)
                     PH_FIRST: begin
                        first_in = parsed;
                        phase_in = PH_OPER;
                     end
                     PH_OPER: begin
                        if (line_start_ff) begin
                           op_in = '0;
                        end
                        phase_in = PH_SECOND;
                     end
                     PH_SECOND: begin
                        second_in = parsed;
                        phase_in  = PH_CALC;
                     end
                     default: begin
                        phase_in = PH_FIRST;
                        cnt_in   = '0;
                        acc_in   = '0;
                        carry_in = 1'b0;
                        qneg_in  = 1'b0;
                        stat_in  = STAT_OK;
                        mode_in  = MODE_ADD;
                        x_in     = first_ff;
                        y_in     = second_ff;
                        state_in = ST_RUN;
                        case (op_ff)
                           CHAR_PLUS: begin
                           end
                           CHAR_MINUS: begin
                              y_in     = ~second_ff;
                              carry_in = 1'b1;
                           end
                           CHAR_X: begin
                              mode_in = MODE_MUL;
                           end
                           CHAR_SLASH: begin
                              if (second_ff == '0) begin
                                 stat_in  = STAT_DIV_ZERO;
                                 state_in = ST_DONE;
                              end else begin
                                 mode_in = MODE_DIV;
                                 x_in    = mag_a;
                                 y_in    = mag_b;
                                 qneg_in = first_ff[W-1] ^ second_ff[W-1];
                              end
                           end
                           default: begin
                              stat_in  = STAT_BAD_OP;
                              state_in = ST_DONE;
                           end
                        endcase
                     end
                  endcase
                  accum_in      = '0;
                  pstep_in      = PS_BLANK;
                  neg_sign_in   = 1'b0;
                  line_start_in = 1'b1;
               end else begin
                  if ((phase_ff == PH_OPER) && line_start_ff) begin
                     op_in = req_rx_byte;
                  end
                  line_start_in = 1'b0;
                  case (pstep_ff)
                     PS_BLANK: begin
                        if (!is_blank) begin
                           if ((req_rx_byte == CHAR_PLUS) || (req_rx_byte == CHAR_MINUS)) begin
                              neg_sign_in = (req_rx_byte == CHAR_MINUS);
                              pstep_in    = PS_DIGITS;
                           end else if (is_digit) begin
                              accum_in = W'(digit);
                              pstep_in = PS_DIGITS;
                           end else begin
                              pstep_in = PS_STOP;
                           end
                        end
                     end
                     PS_DIGITS: begin
                        if (is_digit) begin
                           accum_in = accum_x10;
                        end else begin
                           pstep_in = PS_STOP;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_RUN: begin
            case (mode_ff)
               MODE_ADD: begin
                  acc_in   = {1'b0, sum_bit, acc_ff[W-1:1]};
                  carry_in = sum_carry;
                  x_in     = {1'b0, x_ff[W-1:1]};
                  y_in     = {1'b0, y_ff[W-1:1]};
               end
               MODE_MUL: begin
                  if (y_ff[0]) begin
                     acc_in = {1'b0, acc_ff[W-1:0] + x_ff};
                  end
                  x_in = {x_ff[W-2:0], 1'b0};
                  y_in = {1'b0, y_ff[W-1:1]};
               end
               default: begin
                  if (!rem_diff[W]) begin
                     acc_in = rem_diff;
                     x_in   = {x_ff[W-2:0], 1'b1};
                  end else begin
                     acc_in = rem_shift;
                     x_in   = {x_ff[W-2:0], 1'b0};
                  end
               end
            endcase
            if (cnt_ff == CNT_W'(W - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = final_wide[RESULT_WIDTH-1:0];
               rsp_status_in = stat_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_FIRST;
         first_ff      <= '0;
         second_ff     <= '0;
         op_ff         <= '0;
         accum_ff      <= '0;
         pstep_ff      <= PS_BLANK;
         neg_sign_ff   <= 1'b0;
         line_start_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         op_ff         <= op_in;
         accum_ff      <= accum_in;
         pstep_ff      <= pstep_in;
         neg_sign_ff   <= neg_sign_in;
         line_start_ff <= line_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cnt_ff        <= cnt_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      carry_ff      <= carry_in;
      qneg_ff       <= qneg_in;
      stat_ff       <= stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_line_four_op_calculator. Bytes are fed one
// transaction at a time with random gaps; a local model of the line parser
// and arithmetic tracks every accepted byte and queues the answer due at each
// compute line end. Results are drained under random stall and compared field
// by field against the oldest queued answer. Directed lines cover the signed
// extremes, empty lines, divide by zero and unknown operators; the random
// part sends mostly complete calculations with random operands and text,
// mixed with raw noise bytes and stray line ends.
// ----------------------------------------------------------------------------
module tb;
   import slcalc_pkg::*;

   localparam int DW         = DATA_WIDTH_DEFAULT;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_BYTES = 400;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] value;
      logic [STATUS_WIDTH-1:0]        status;
   } answer_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [BYTE_WIDTH-1:0]          req_rx_byte;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [RESULT_WIDTH-1:0] rsp_result_value;
   logic [STATUS_WIDTH-1:0]        rsp_status;

   serial_line_four_op_calculator #(
      .DATA_WIDTH (DW)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   // calculator model state
   logic [1:0]    m_phase;
   logic [1:0]    m_step;
   logic [DW-1:0] m_first;
   logic [DW-1:0] m_second;
   logic [DW-1:0] m_accum;
   logic [7:0]    m_oper;
   logic          m_neg;
   logic          m_line_start;

   answer_type    pending_answers[$];
   logic [7:0]    tx_bytes[$];

   bit            no_gaps;
   int            bytes_sent;
   int            answers_seen;
   int            mismatches;
   int            status_seen[3];
   int            rsp_wait;
   int            idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [DW-1:0] magnitude_of(input logic [DW-1:0] v);
      return v[DW-1] ? -v : v;
   endfunction

   function automatic answer_type arith_answer();
      answer_type    r;
      logic [DW-1:0] q;
      r.value  = '0;
      r.status = STAT_OK;
      case (m_oper)
         CHAR_PLUS:  r.value = m_first + m_second;
         CHAR_MINUS: r.value = m_first - m_second;
         CHAR_X:     r.value = m_first * m_second;
         CHAR_SLASH: begin
            if (m_second == '0) begin
               r.status = STAT_DIV_ZERO;
            end else begin
               q = magnitude_of(m_first) / magnitude_of(m_second);
               if (m_first[DW-1] ^ m_second[DW-1]) q = -q;
               r.value = q;
            end
         end
         default: r.status = STAT_BAD_OP;
      endcase
      return r;
   endfunction

   task automatic reset_model();
      m_phase      = PH_FIRST;
      m_step       = PS_BLANK;
      m_first      = '0;
      m_second     = '0;
      m_accum      = '0;
      m_oper       = '0;
      m_neg        = 1'b0;
      m_line_start = 1'b1;
   endtask

   task automatic track_calculator_byte(input logic [7:0] b);
      logic is_digit;
      logic is_blank;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      is_blank = (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_SPACE);
      if (b == CHAR_LF || b == CHAR_CR) begin
         case (m_phase)
            PH_FIRST:  m_first = m_neg ? -m_accum : m_accum;
            PH_OPER:   if (m_line_start) m_oper = '0;
            PH_SECOND: m_second = m_neg ? -m_accum : m_accum;
            default:   pending_answers.push_back(arith_answer());
         endcase
         m_phase      = m_phase + 2'd1;
         m_accum      = '0;
         m_step       = PS_BLANK;
         m_neg        = 1'b0;
         m_line_start = 1'b1;
      end else begin
         if (m_phase == PH_OPER && m_line_start) m_oper = b;
         m_line_start = 1'b0;
         case (m_step)
            PS_BLANK: begin
               if (is_blank) begin
               end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                  m_neg  = (b == CHAR_MINUS);
                  m_step = PS_DIGITS;
               end else if (is_digit) begin
                  m_accum = DW'(b - CHAR_ZERO);
                  m_step  = PS_DIGITS;
               end else begin
                  m_step = PS_STOP;
               end
            end
            PS_DIGITS: begin
               if (is_digit) m_accum = DW'(m_accum * 10 + (b - CHAR_ZERO));
               else m_step = PS_STOP;
            end
            default: ;
         endcase
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_calculator_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_tx_bytes();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
   endtask

   task automatic check_answer();
      answer_type want;
      if (pending_answers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: value %0d status %0d", rsp_result_value, rsp_status);
      end else begin
         want = pending_answers.pop_front();
         answers_seen++;
         if (want.status < 3) status_seen[want.status]++;
         if (rsp_result_value !== want.value || rsp_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: value exp %0d act %0d, status exp %0d act %0d",
                        want.value, rsp_result_value, want.status, rsp_status);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  = 0;
      end else if (rsp_valid && !rsp_stall) begin
         check_answer();
         rsp_wait = no_gaps ? 0 : $urandom_range(0, 13);
         rsp_stall <= (rsp_wait != 0);
      end else if (rsp_valid && rsp_wait != 0) begin
         rsp_wait = rsp_wait - 1;
         if (rsp_wait == 0) rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = CHAR_LF;
      while (b == CHAR_LF || b == CHAR_CR) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0:       return CHAR_TAB;
         1:       return CHAR_VT;
         2:       return CHAR_FF;
         default: return CHAR_SPACE;
      endcase
   endfunction

   task automatic add_line_end();
      tx_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic add_text(input int most);
      repeat ($urandom_range(1, most)) tx_bytes.push_back(text_byte());
   endtask

   task automatic add_decimal(input longint unsigned v);
      logic [7:0] digits[$];
      if (v == 0) digits.push_back(CHAR_ZERO);
      while (v != 0) begin
         digits.push_front(CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end
      while (digits.size() != 0) tx_bytes.push_back(digits.pop_front());
   endtask

   task automatic add_operand_line();
      longint unsigned extremes[7];
      extremes = '{0, 1, 32767, 32768, 65535, 65536, 99999999};
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) tx_bytes.push_back(blank_byte());
      case ($urandom_range(0, 5))
         0:       tx_bytes.push_back(CHAR_PLUS);
         1, 2:    tx_bytes.push_back(CHAR_MINUS);
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: add_decimal(64'($urandom_range(0, 65535)));
         4:          add_decimal(extremes[$urandom_range(0, 6)]);
         5:          repeat ($urandom_range(6, 12))
                        tx_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         6:          ;
         default:    add_decimal(64'($urandom_range(0, 20)));
      endcase
      if ($urandom_range(0, 4) == 0) add_text(3);
      add_line_end();
   endtask

   task automatic add_operator_line();
      case ($urandom_range(0, 9))
         0, 1:    tx_bytes.push_back(CHAR_PLUS);
         2, 3:    tx_bytes.push_back(CHAR_MINUS);
         4, 5:    tx_bytes.push_back(CHAR_X);
         6, 7:    tx_bytes.push_back(CHAR_SLASH);
         8:       tx_bytes.push_back(text_byte());
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0) add_text(3);
      add_line_end();
   endtask

   task automatic add_compute_line();
      if ($urandom_range(0, 2) == 0) add_text(3);
      add_line_end();
   endtask

   task automatic test_signed_extremes();
      // \015 is CR, \012 LF, \011 tab
      send_text(" -32768x\015/\015-1\015\015");
   endtask

   task automatic test_empty_lines();
      no_gaps = 1'b1;
      send_text("\015\015\015\015");
      send_text("\011+\015x\015\015\012");
      no_gaps = 1'b0;
   endtask

   task automatic test_divide_by_zero();
      send_text("5\015/\0150\015\015");
   endtask

   task automatic test_unknown_operator();
      send_text("3\015?\0153\015\015");
   endtask

   task automatic test_random_calculations();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 7) == 0) begin
            // raw noise, may include stray line ends or CRLF pairs
            repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
               tx_bytes.push_back(CHAR_CR);
               tx_bytes.push_back(CHAR_LF);
            end
            send_tx_bytes();
         end
         while (m_phase != PH_FIRST) begin
            add_line_end();
            send_tx_bytes();
         end
         add_operand_line();
         add_operator_line();
         add_operand_line();
         add_compute_line();
         send_tx_bytes();
      end
      no_gaps = 1'b0;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      no_gaps      = 1'b0;
      bytes_sent   = 0;
      answers_seen = 0;
      mismatches   = 0;
      status_seen  = '{0, 0, 0};
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_signed_extremes();
      test_empty_lines();
      test_divide_by_zero();
      test_unknown_operator();
      test_random_calculations();
      wait_for_answers();

      mismatches += pending_answers.size();
      $display("sent %0d bytes, checked %0d results: %0d ok, %0d divide by zero, %0d bad operator",
               bytes_sent, answers_seen, status_seen[STAT_OK], status_seen[STAT_DIV_ZERO],
               status_seen[STAT_BAD_OP]);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
